// ----- rtl/sshm_pkg.sv -----
// Shared constants, register codes and divider types for the stream health monitor.
package sshm_pkg;

    localparam int TIME_W     = 48;
    localparam int CNT_W      = 32;
    localparam int EVT_W      = 16;
    localparam int RATE_W     = 32;
    localparam int TOL_W      = 24;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;
    localparam int WINDOW_DEPTH_DEF = 16;

    // numerator scale: items per microsecond to millihertz
    localparam logic [29:0] RATE_SCALE = 30'd1000000000;
    localparam int NUM_W = 39; // 9-bit count times 1e9 fits in 39 bits

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ENABLE      = 3'd0,
        REG_TOLERANCE   = 3'd1,
        REG_MAX_STALE   = 3'd2,
        REG_MAX_MSG_AGE = 3'd3,
        REG_MIN_RATE    = 3'd4,
        REG_GRACE       = 3'd5,
        REG_RB_FATAL    = 3'd6,
        REG_DUP_FATAL   = 3'd7
    } cfg_reg_t;

    typedef struct packed {
        logic                start;
        logic [NUM_W-1:0]    numer;
        logic [TIME_W-1:0]   denom;
    } div_req_t;

    typedef struct packed {
        logic                done;
        logic [RATE_W-1:0]   quot;  // saturated
    } div_rsp_t;

endpackage

// ----- rtl/sshm_divider.sv -----
// Bit-serial restoring divider, one quotient bit per cycle, saturating to RATE_W bits.
module sshm_divider
    import sshm_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  div_req_t req,
    output div_rsp_t rsp
);

    localparam int STEP_W = $clog2(NUM_W + 1);

    logic [NUM_W-1:0]  num_reg, num_next;
    logic [NUM_W-1:0]  quo_reg, quo_next;
    logic [TIME_W-1:0] rem_reg, rem_next;
    logic [TIME_W-1:0] den_reg, den_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [TIME_W:0]   trial;

    always_comb begin
        num_next  = num_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {rem_reg, num_reg[NUM_W-1]};
        if (req.start) begin
            num_next  = req.numer;
            den_next  = req.denom;
            rem_next  = '0;
            quo_next  = '0;
            step_next = STEP_W'(NUM_W);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            num_next = {num_reg[NUM_W-2:0], 1'b0};
            if (trial >= {1'b0, den_reg}) begin
                rem_next = TIME_W'(trial - {1'b0, den_reg});
                quo_next = {quo_reg[NUM_W-2:0], 1'b1};
            end else begin
                rem_next = trial[TIME_W-1:0];
                quo_next = {quo_reg[NUM_W-2:0], 1'b0};
            end
            step_next = step_reg - 1'b1;
            if (step_reg == STEP_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        num_reg  <= num_next;
        quo_reg  <= quo_next;
        rem_reg  <= rem_next;
        den_reg  <= den_next;
        step_reg <= step_next;
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    assign rsp.done = done_reg;
    assign rsp.quot = (|quo_reg[NUM_W-1:RATE_W]) ? '1 : quo_reg[RATE_W-1:0];

endmodule

// ----- rtl/sensor_stream_health_monitor_unit.sv -----
// Top level of the stream health monitor: state, receive-time ring, query sequencer.
// One item is taken at a time. An observe item is captured on acceptance, then the stamp
// checks run together with the ring write before the next acceptance. A status item with
// a defined rate goes through capture, age compute, two ring reads, span check, divider
// start, the bit-serial rate divider (one quotient bit per cycle over a 39-bit numerator),
// quotient capture and output load; the output load waits until the previous result has
// been taken. With fewer than two window entries or a span that is not positive the
// divider is skipped. The result sits in an output register and the next item may be
// accepted while it waits.
module sensor_stream_health_monitor_unit
    import sshm_pkg::*;
#(
    parameter int WINDOW_DEPTH = WINDOW_DEPTH_DEF
)(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // tdata: message_stamp_us, receive_time_us, now_message_clock_us, now_steady_us,
    //        startup_elapsed_us (224 bits)
    input  logic [223:0]          s_tdata,
    // tuser: command
    input  logic                  s_tuser,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // tdata: stale, rate_ok, received flag, stamps_monotonic, received_total,
    //        rollback_total_out, duplicate_total_out, receive_age_us, message_age_us,
    //        estimated_rate_mhz, zero fill (200 bits)
    output logic [199:0]          m_tdata,
    // tuser: healthy
    output logic                  m_tuser
);

    localparam int IDX_W  = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
    localparam int FILL_W = $clog2(WINDOW_DEPTH + 1);

    typedef enum logic [3:0] {
        ST_IDLE, ST_OBS, ST_Q_RD, ST_Q_RD2, ST_Q_SPAN, ST_Q_DIV, ST_Q_WAIT, ST_Q_FIN
    } state_t;

    state_t state_reg;

    // configuration
    logic                  enable_reg;
    logic [TOL_W-1:0]      tol_reg;
    logic [31:0]           max_stale_reg, max_age_reg, min_rate_reg, grace_reg;
    logic                  rb_fatal_reg, dup_fatal_reg;

    // captured item
    logic [TIME_W-1:0]     stamp_reg, recv_reg, now_msg_reg, now_st_reg;
    logic [31:0]           elapsed_reg;

    // monitor state
    logic                  rcvd_reg, mono_reg;
    logic [TIME_W-1:0]     last_recv_reg, last_stamp_reg;
    logic [CNT_W-1:0]      msg_cnt_reg;
    logic [EVT_W-1:0]      rb_cnt_reg, dup_cnt_reg;
    logic [IDX_W-1:0]      oldest_reg;
    logic [FILL_W-1:0]     fill_reg;
    logic [TIME_W-1:0]     ring_mem [WINDOW_DEPTH];
    logic [TIME_W-1:0]     rd_data_reg, first_reg;

    // query work registers
    logic [TIME_W-1:0]     rage_reg, mage_reg;
    logic [RATE_W-1:0]     rate_reg;
    logic                  span_pos_reg;

    // result register
    logic                  out_valid_reg;
    logic [199:0]          out_data_reg;
    logic                  out_user_reg;

    div_req_t div_req;
    div_rsp_t div_rsp;

    logic                  in_acc, out_acc;
    logic [IDX_W-1:0]      wr_idx, last_idx;
    logic [FILL_W:0]       wsum, lsum;
    logic [TIME_W:0]       diff_up, diff_dn;
    logic                  back, dup;
    logic [TIME_W-1:0]     span;
    logic [NUM_W-1:0]      numer;
    logic                  stale, rok, healthy, fill_ge2;

    assign in_acc    = s_tvalid && s_tready;
    assign out_acc   = m_tvalid && m_tready;
    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == ST_IDLE);

    // ring address arithmetic, mod depth by one compare and subtract
    assign wsum = (FILL_W+1)'(oldest_reg) + (FILL_W+1)'(fill_reg);
    assign lsum = wsum - 1'b1;
    assign wr_idx = (fill_reg == FILL_W'(WINDOW_DEPTH)) ? oldest_reg :
        ((wsum >= (FILL_W+1)'(WINDOW_DEPTH)) ? IDX_W'(wsum - (FILL_W+1)'(WINDOW_DEPTH))
                                              : IDX_W'(wsum));
    assign last_idx = (lsum >= (FILL_W+1)'(WINDOW_DEPTH))
        ? IDX_W'(lsum - (FILL_W+1)'(WINDOW_DEPTH)) : IDX_W'(lsum);

    assign diff_up = {1'b0, stamp_reg} - {1'b0, last_stamp_reg};
    assign diff_dn = {1'b0, last_stamp_reg} - {1'b0, stamp_reg};
    always_comb begin
        if (!diff_up[TIME_W]) begin
            back = 1'b0;
            dup  = diff_up[TIME_W-1:0] <= {{(TIME_W-TOL_W){1'b0}}, tol_reg};
        end else begin
            back = diff_dn[TIME_W-1:0] > {{(TIME_W-TOL_W){1'b0}}, tol_reg};
            dup  = !back;
        end
    end

    assign span  = rd_data_reg - first_reg;
    assign numer = NUM_W'((fill_reg - 1'b1)) * NUM_W'(RATE_SCALE);

    assign div_req.start = (state_reg == ST_Q_DIV);
    assign div_req.numer = numer;
    assign div_req.denom = span;

    sshm_divider u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    assign fill_ge2 = fill_reg >= FILL_W'(2);
    assign stale = !rcvd_reg || (rage_reg > {16'd0, max_stale_reg})
                   || (mage_reg > {16'd0, max_age_reg});
    assign rok = (elapsed_reg < grace_reg) || !fill_ge2 || (rate_reg >= min_rate_reg);
    assign healthy = enable_reg && rcvd_reg && !stale && rok
                     && !(!mono_reg && rb_fatal_reg)
                     && !(dup_fatal_reg && (dup_cnt_reg != '0));

    always_ff @(posedge aclk) begin
        if (state_reg == ST_OBS) begin
            ring_mem[wr_idx] <= recv_reg;
        end
        if (state_reg == ST_Q_RD) begin
            rd_data_reg <= ring_mem[oldest_reg];
        end else if (state_reg == ST_Q_RD2) begin
            rd_data_reg <= ring_mem[last_idx];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            enable_reg     <= 1'b1;
            tol_reg        <= '0;
            max_stale_reg  <= 32'd1000000;
            max_age_reg    <= 32'd1000000;
            min_rate_reg   <= '0;
            grace_reg      <= '0;
            rb_fatal_reg   <= 1'b0;
            dup_fatal_reg  <= 1'b0;
            rcvd_reg       <= 1'b0;
            mono_reg       <= 1'b1;
            last_recv_reg  <= '0;
            last_stamp_reg <= '0;
            msg_cnt_reg    <= '0;
            rb_cnt_reg     <= '0;
            dup_cnt_reg    <= '0;
            oldest_reg     <= '0;
            fill_reg       <= '0;
            out_valid_reg  <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                unique case (cfg_reg_t'(cfg_index))
                    REG_ENABLE:      enable_reg    <= cfg_data[0];
                    REG_TOLERANCE:   tol_reg       <= cfg_data[TOL_W-1:0];
                    REG_MAX_STALE:   max_stale_reg <= cfg_data;
                    REG_MAX_MSG_AGE: max_age_reg   <= cfg_data;
                    REG_MIN_RATE:    min_rate_reg  <= cfg_data;
                    REG_GRACE:       grace_reg     <= cfg_data;
                    REG_RB_FATAL:    rb_fatal_reg  <= cfg_data[0];
                    REG_DUP_FATAL:   dup_fatal_reg <= cfg_data[0];
                    default: ;
                endcase
            end
            if (out_acc) begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (in_acc) begin
                        stamp_reg   <= s_tdata[47:0];
                        recv_reg    <= s_tdata[95:48];
                        now_msg_reg <= s_tdata[143:96];
                        now_st_reg  <= s_tdata[191:144];
                        elapsed_reg <= s_tdata[223:192];
                        state_reg   <= s_tuser ? ST_Q_RD : ST_OBS;
                    end
                end
                ST_OBS: begin
                    if (rcvd_reg) begin
                        if (back) begin
                            if (rb_cnt_reg != '1) rb_cnt_reg <= rb_cnt_reg + 1'b1;
                            mono_reg <= 1'b0;
                        end else if (dup) begin
                            if (dup_cnt_reg != '1) dup_cnt_reg <= dup_cnt_reg + 1'b1;
                        end
                    end
                    rcvd_reg       <= 1'b1;
                    last_recv_reg  <= recv_reg;
                    last_stamp_reg <= stamp_reg;
                    if (msg_cnt_reg != '1) msg_cnt_reg <= msg_cnt_reg + 1'b1;
                    if (fill_reg == FILL_W'(WINDOW_DEPTH)) begin
                        oldest_reg <= (oldest_reg == IDX_W'(WINDOW_DEPTH - 1))
                                      ? '0 : oldest_reg + 1'b1;
                    end else begin
                        fill_reg <= fill_reg + 1'b1;
                    end
                    state_reg <= ST_IDLE;
                end
                ST_Q_RD: begin
                    if (!rcvd_reg) begin
                        rage_reg <= '1;
                        mage_reg <= '1;
                    end else begin
                        rage_reg <= (now_st_reg > last_recv_reg)
                                    ? now_st_reg - last_recv_reg : '0;
                        mage_reg <= (now_msg_reg > last_stamp_reg)
                                    ? now_msg_reg - last_stamp_reg : '0;
                    end
                    state_reg <= ST_Q_RD2;
                end
                ST_Q_RD2: begin
                    first_reg <= rd_data_reg;
                    state_reg <= ST_Q_SPAN;
                end
                ST_Q_SPAN: begin
                    span_pos_reg <= fill_ge2 && (rd_data_reg > first_reg);
                    rate_reg     <= '0;
                    state_reg    <= (fill_ge2 && (rd_data_reg > first_reg))
                                    ? ST_Q_DIV : ST_Q_FIN;
                end
                ST_Q_DIV: begin
                    state_reg <= ST_Q_WAIT;
                end
                ST_Q_WAIT: begin
                    if (div_rsp.done) begin
                        rate_reg  <= div_rsp.quot;
                        state_reg <= ST_Q_FIN;
                    end
                end
                ST_Q_FIN: begin
                    if (!out_valid_reg) begin
                        out_valid_reg <= 1'b1;
                        out_user_reg  <= healthy;
                        out_data_reg  <= {4'd0, rate_reg, mage_reg, rage_reg,
                                          dup_cnt_reg, rb_cnt_reg, msg_cnt_reg,
                                          mono_reg, rcvd_reg, rok, stale};
                        state_reg     <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;

`ifndef SYNTHESIS
    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= FILL_W'(WINDOW_DEPTH))
        else $error("window fill above depth");
    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_IDLE) |-> !s_tready)
        else $error("item accepted while busy");
    a_div_rate: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_Q_FIN && !span_pos_reg) |-> (rate_reg == '0))
        else $error("rate nonzero for undefined span");
    a_obs_no_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_OBS) |=> !$rose(out_valid_reg))
        else $error("observe produced a result");
`endif

endmodule

// ----- tb/sensor_stream_health_monitor_unit_tb.sv -----
// Self-checking testbench for the stream health monitor: directed and random items.
`timescale 1ns / 100ps

module sensor_stream_health_monitor_unit_tb;
    import sshm_pkg::*;

    localparam logic [47:0] ALL48 = 48'hFFFF_FFFF_FFFF;
    localparam int RING_DEPTH = 16;

    typedef struct {
        bit        cmd;
        bit [47:0] stamp;
        bit [47:0] recv;
        bit [47:0] now_msg;
        bit [47:0] now_st;
        bit [31:0] elapsed;
    } item_t;

    typedef struct {
        bit        healthy;
        bit        stale;
        bit        rate_ok;
        bit        received;
        bit        monotonic;
        bit [31:0] msg_total;
        bit [15:0] rb_total;
        bit [15:0] dup_total;
        bit [47:0] recv_age;
        bit [47:0] msg_age;
        bit [31:0] rate;
    } status_t;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         cfg_valid = 1'b0;
    logic         cfg_ready;
    logic [2:0]   cfg_index = '0;
    logic [31:0]  cfg_data = '0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [223:0] s_tdata = '0;
    logic         s_tuser = 1'b0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [199:0] m_tdata;
    logic         m_tuser;

    sensor_stream_health_monitor_unit u_top (.*);

    item_t   pending_items[$];
    status_t expected_status[$];
    int      fail_count = 0;
    bit      no_idle = 1'b0;

    // configuration copy
    bit        mon_enable = 1'b1;
    bit [23:0] tol_us = '0;
    bit [31:0] stale_limit = 32'd1000000;
    bit [31:0] age_limit = 32'd1000000;
    bit [31:0] min_rate = '0;
    bit [31:0] grace_us = '0;
    bit        rb_fatal = 1'b0;
    bit        dup_fatal = 1'b0;

    // monitored-stream state
    bit        seen_any = 1'b0;
    bit        mono = 1'b1;
    bit [47:0] last_recv = '0;
    bit [47:0] last_stamp = '0;
    bit [31:0] msg_cnt = '0;
    bit [15:0] rb_cnt = '0;
    bit [15:0] dup_cnt = '0;
    bit [47:0] ring[RING_DEPTH];
    int        ring_head = 0;
    int        ring_fill = 0;

    initial begin
        forever #6 aclk = ~aclk;
    end

    function automatic bit [31:0] ring_rate();
        bit [47:0] first, newest;
        longint unsigned q;
        if (ring_fill < 2) return '0;
        first  = ring[ring_head];
        newest = ring[(ring_head + ring_fill - 1) % RING_DEPTH];
        if (newest <= first) return '0;
        q = (longint'(ring_fill - 1) * 64'd1000000000) / (newest - first);
        return (q > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : q[31:0];
    endfunction

    task automatic track_item(input item_t it);
        status_t st;
        bit back, dup;
        if (!it.cmd) begin
            if (seen_any) begin
                if (it.stamp >= last_stamp) begin
                    back = 1'b0;
                    dup = (it.stamp - last_stamp) <= tol_us;
                end else begin
                    back = (last_stamp - it.stamp) > tol_us;
                    dup = !back;
                end
                if (back) begin
                    if (rb_cnt != 16'hFFFF) rb_cnt++;
                    mono = 1'b0;
                end else if (dup && dup_cnt != 16'hFFFF) begin
                    dup_cnt++;
                end
            end
            seen_any = 1'b1;
            last_recv = it.recv;
            last_stamp = it.stamp;
            if (msg_cnt != 32'hFFFF_FFFF) msg_cnt++;
            if (ring_fill < RING_DEPTH) begin
                ring[(ring_head + ring_fill) % RING_DEPTH] = it.recv;
                ring_fill++;
            end else begin
                ring[ring_head] = it.recv;
                ring_head = (ring_head + 1) % RING_DEPTH;
            end
            return;
        end
        if (!seen_any) begin
            st.recv_age = ALL48;
            st.msg_age = ALL48;
        end else begin
            st.recv_age = (it.now_st > last_recv) ? it.now_st - last_recv : '0;
            st.msg_age = (it.now_msg > last_stamp) ? it.now_msg - last_stamp : '0;
        end
        st.stale = !seen_any || st.recv_age > stale_limit || st.msg_age > age_limit;
        st.rate = ring_rate();
        st.rate_ok = (it.elapsed < grace_us) || ring_fill < 2 || st.rate >= min_rate;
        st.healthy = mon_enable && seen_any && !st.stale && st.rate_ok &&
                     !(!mono && rb_fatal) && !(dup_fatal && dup_cnt != 0);
        st.received = seen_any;
        st.monotonic = mono;
        st.msg_total = msg_cnt;
        st.rb_total = rb_cnt;
        st.dup_total = dup_cnt;
        expected_status.insert(expected_status.size(), st);
    endtask

    // driver
    always @(posedge aclk) begin
        item_t it;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                it.cmd = s_tuser;
                {it.elapsed, it.now_st, it.now_msg, it.recv, it.stamp} = s_tdata;
                track_item(it);
            end
            if (!(s_tvalid && !s_tready)) begin
                if (pending_items.size() != 0 && (no_idle || $urandom_range(0, 99) >= 32)) begin
                    it = pending_items[0];
                    pending_items.delete(0);
                    s_tvalid <= 1'b1;
                    s_tuser <= it.cmd;
                    s_tdata <= {it.elapsed, it.now_st, it.now_msg, it.recv, it.stamp};
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    task automatic report_mismatch(input string what, input longint unsigned got,
                                   input longint unsigned want);
        $display("MISMATCH %s: got %0h expected %0h at %0t", what, got, want, $time);
        fail_count++;
    endtask

    // monitor
    always @(posedge aclk) begin
        status_t st;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            m_tready <= no_idle || $urandom_range(0, 99) >= 32;
            if (m_tvalid && m_tready) begin
                if (expected_status.size() == 0) begin
                    report_mismatch("unexpected status item", m_tdata[35:4], 0);
                end else begin
                    st = expected_status[0];
                    expected_status.delete(0);
                    if (m_tuser !== st.healthy) report_mismatch("healthy", m_tuser, st.healthy);
                    if (m_tdata[0] !== st.stale) report_mismatch("stale", m_tdata[0], st.stale);
                    if (m_tdata[1] !== st.rate_ok)
                        report_mismatch("rate_ok", m_tdata[1], st.rate_ok);
                    if (m_tdata[2] !== st.received)
                        report_mismatch("received_flag", m_tdata[2], st.received);
                    if (m_tdata[3] !== st.monotonic)
                        report_mismatch("stamps_monotonic", m_tdata[3], st.monotonic);
                    if (m_tdata[35:4] !== st.msg_total)
                        report_mismatch("received_total", m_tdata[35:4], st.msg_total);
                    if (m_tdata[51:36] !== st.rb_total)
                        report_mismatch("rollback_total", m_tdata[51:36], st.rb_total);
                    if (m_tdata[67:52] !== st.dup_total)
                        report_mismatch("duplicate_total", m_tdata[67:52], st.dup_total);
                    if (m_tdata[115:68] !== st.recv_age)
                        report_mismatch("receive_age", m_tdata[115:68], st.recv_age);
                    if (m_tdata[163:116] !== st.msg_age)
                        report_mismatch("message_age", m_tdata[163:116], st.msg_age);
                    if (m_tdata[195:164] !== st.rate)
                        report_mismatch("estimated_rate", m_tdata[195:164], st.rate);
                end
            end
        end
    end

    function automatic bit [47:0] rand48();
        return {$urandom, $urandom};
    endfunction

    task automatic add_observe(input bit [47:0] stamp, input bit [47:0] recv);
        item_t it;
        it = '{cmd: 1'b0, stamp: stamp, recv: recv, now_msg: rand48(), now_st: rand48(),
               elapsed: $urandom};
        pending_items.insert(pending_items.size(), it);
    endtask

    task automatic add_query(input bit [47:0] nm, input bit [47:0] ns, input bit [31:0] el);
        item_t it;
        it = '{cmd: 1'b1, stamp: rand48(), recv: rand48(), now_msg: nm, now_st: ns,
               elapsed: el};
        pending_items.insert(pending_items.size(), it);
    endtask

    task automatic drain();
        while (pending_items.size() != 0 || s_tvalid || expected_status.size() != 0)
            @(posedge aclk);
        repeat (80) @(posedge aclk);
    endtask

    task automatic write_reg(input cfg_reg_t idx, input bit [31:0] val);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        case (idx)
            REG_ENABLE:      mon_enable = val[0];
            REG_TOLERANCE:   tol_us = val[23:0];
            REG_MAX_STALE:   stale_limit = val;
            REG_MAX_MSG_AGE: age_limit = val;
            REG_MIN_RATE:    min_rate = val;
            REG_GRACE:       grace_us = val;
            REG_RB_FATAL:    rb_fatal = val[0];
            REG_DUP_FATAL:   dup_fatal = val[0];
            default: ;
        endcase
        cfg_valid <= 1'b0;
    endtask

    // offset near a limit: zero, at, just past, a small random offset, or anywhere up to twice the limit
    function automatic bit [47:0] near_limit(input bit [31:0] lim);
        case ($urandom_range(0, 4))
            0: return '0;
            1: return lim;
            2: return {16'd0, lim} + 48'd1;
            3: return $urandom_range(0, 2000);
            default: return ({16'd0, lim} * 2) * $urandom_range(0, 100) / 100;
        endcase
    endfunction

    task automatic random_items(input int count);
        bit [47:0] gs, gr, step;
        bit [47:0] nm, ns;
        int r;
        gs = $urandom_range(0, 1 << 20);
        gr = $urandom_range(0, 1 << 20);
        for (int n = 0; n < count; n++) begin
            r = $urandom_range(0, 99);
            if (r < 48) begin
                case ($urandom_range(0, 5))
                    0: gs = gs;
                    1: gs = gs + $urandom_range(0, tol_us);
                    2: gs = gs + tol_us + 1 + $urandom_range(0, 5000);
                    3: gs = (gs > tol_us) ? gs - $urandom_range(0, tol_us) : gs;
                    4: gs = (gs > tol_us + 1) ? gs - tol_us - 1 : gs;
                    default: gs = gs + $urandom_range(500, 1500);
                endcase
                step = ($urandom_range(0, 9) == 0) ? 48'd0 : $urandom_range(1, 3000);
                gr = gr + step;
                add_observe(gs, gr);
            end else if (r < 92) begin
                nm = ($urandom_range(0, 9) == 0) ? gs - $urandom_range(0, 100)
                                                 : gs + near_limit(age_limit);
                ns = ($urandom_range(0, 9) == 0) ? gr - $urandom_range(0, 100)
                                                 : gr + near_limit(stale_limit);
                add_query(nm, ns, ($urandom_range(0, 1)) ? $urandom_range(0, 2 * grace_us)
                                                         : $urandom);
            end else if (r < 96) begin
                add_query(rand48(), rand48(), $urandom);
            end else begin
                add_observe(rand48(), rand48());
            end
        end
    endtask

    task automatic write_all(input bit [31:0] v[8]);
        write_reg(REG_ENABLE, v[0]);
        write_reg(REG_TOLERANCE, v[1]);
        write_reg(REG_MAX_STALE, v[2]);
        write_reg(REG_MAX_MSG_AGE, v[3]);
        write_reg(REG_MIN_RATE, v[4]);
        write_reg(REG_GRACE, v[5]);
        write_reg(REG_RB_FATAL, v[6]);
        write_reg(REG_DUP_FATAL, v[7]);
    endtask

    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        // directed, reset configuration
        add_query(48'd5, 48'd5, 32'd0);            // nothing received yet
        add_observe(48'd1000, 48'd5000);           // first item, no stamp checks
        add_observe(48'd1000, 48'd5000);           // duplicate
        add_observe(48'd900, 48'd5000);            // rollback
        add_observe(48'd2000, 48'd5000);           // zero span
        add_query(48'd2000, 48'd5000, 32'd0);
        add_observe(ALL48, ALL48);
        add_query(ALL48, ALL48, 32'hFFFF_FFFF);
        add_query(48'd0, 48'd0, 32'd0);            // ages floor at zero
        add_observe(48'd0, 48'd0);                 // newest below oldest
        add_query(48'd1, 48'd1, 32'd0);
        for (int i = 1; i <= 14; i++)
            add_observe(48'd100 * i, 48'd1000 * i);  // fills and wraps the ring
        add_query(48'd1500, 48'd14500, 32'd0);
        drain();

        // extremes: everything at its top
        write_all('{1, 32'hFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                    32'hFFFF_FFFF, 1, 1});
        random_items(140);
        drain();

        // everything at its bottom, with no idling
        no_idle = 1'b1;
        write_all('{0, 0, 0, 0, 0, 0, 0, 0});
        random_items(140);
        drain();
        no_idle = 1'b0;

        // realistic limits around a kilohertz stream
        write_all('{1, 300, 2000, 2000, 700000, 50000, 1, 0});
        random_items(140);
        drain();

        for (int p = 0; p < 2; p++) begin
            write_all('{$urandom_range(0, 1), $urandom_range(0, 3000),
                        $urandom_range(0, 5000), $urandom_range(0, 5000),
                        $urandom_range(0, 2000000), $urandom_range(0, 100000),
                        $urandom_range(0, 1), $urandom_range(0, 1)});
            random_items(140);
            drain();
        end

        if (fail_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    initial begin
        #30ms;
        $display("Some tests failed");
        $finish;
    end

endmodule
